// ----- rtl/cfc_pkg.sv -----
// ----------------------------------------------------------------------------
// cfc_pkg
// shared types and constants for the credit flow controller
// ----------------------------------------------------------------------------
`default_nettype none

package cfc_pkg;

    localparam int OffsetBits = 62;
    localparam int StatusBits = 2;
    localparam int OpcodeBits = 3;
    localparam int CfgIndexBits = 2;

    localparam logic [OffsetBits-1:0] OffsetMax = {OffsetBits{1'b1}};
    localparam logic [OffsetBits-1:0] InitialLimit = OffsetBits'(16384);

    // event codes
    typedef enum logic [OpcodeBits-1:0] {
        OP_CONSUMED    = 3'd0,
        OP_BUFFERED    = 3'd1,
        OP_UNBUFFER    = 3'd2,
        OP_SENT        = 3'd3,
        OP_SEND_LIMIT  = 3'd4,
        OP_CHK_UPDATE  = 3'd5,
        OP_CHK_BLOCKED = 3'd6
    } opcode_t;

    // result status codes
    localparam logic [StatusBits-1:0] ST_OK          = 2'd0;
    localparam logic [StatusBits-1:0] ST_UNDERFLOW   = 2'd1;
    localparam logic [StatusBits-1:0] ST_OVERRUN     = 2'd2;
    localparam logic [StatusBits-1:0] ST_NOT_RAISED  = 2'd3;

    // configuration register indexes
    localparam logic [CfgIndexBits-1:0] CFG_ENABLE        = 2'd0;
    localparam logic [CfgIndexBits-1:0] CFG_INIT_SEND     = 2'd1;
    localparam logic [CfgIndexBits-1:0] CFG_INIT_RECEIVE  = 2'd2;
    localparam logic [CfgIndexBits-1:0] CFG_MAX_RX_WINDOW = 2'd3;

    typedef struct packed {
        logic                  enable;
        logic [OffsetBits-1:0] rx_window_max;
    } cfg_t;

    typedef struct packed {
        logic                  send_load;
        logic                  receive_load;
        logic [OffsetBits-1:0] value;
    } limit_load_t;

    typedef struct packed {
        logic [StatusBits-1:0] status;
        logic [OffsetBits-1:0] tx_credit;
        logic                  is_blocked;
        logic                  violation;
        logic                  update_sent;
        logic [OffsetBits-1:0] update_offset;
        logic                  blocked_sent;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/cfc_core.sv -----
// ----------------------------------------------------------------------------
// cfc_core
// flow control counters and the per-event update and result logic
// ----------------------------------------------------------------------------
`default_nettype none

module cfc_core (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               advance,
    input  wire logic [cfc_pkg::OpcodeBits-1:0]     opcode,
    input  wire logic [cfc_pkg::OffsetBits-1:0]     amount,
    input  wire cfc_pkg::cfg_t                      cfg,
    input  wire cfc_pkg::limit_load_t               load,
    output cfc_pkg::result_t                        result
);

    localparam int W = cfc_pkg::OffsetBits;

    logic [W-1:0] consumed_reg, consumed_next;
    logic [W-1:0] buffered_reg, buffered_next;
    logic [W-1:0] sent_reg, sent_next;
    logic [W-1:0] send_limit_reg, send_limit_next;
    logic [W-1:0] receive_limit_reg, receive_limit_next;
    logic [W-1:0] last_blocked_reg, last_blocked_next;

    logic [cfc_pkg::StatusBits-1:0] status;
    logic                           upd;
    logic                           blk;
    logic [W:0]                     sum_c;
    logic [W:0]                     sum_b;
    logic [W:0]                     sum_s;
    logic [W:0]                     sum_r;
    logic [W:0]                     sum_cb;
    logic [W-1:0]                   left;
    logic [W-1:0]                   window;

    always_comb begin
        consumed_next      = consumed_reg;
        buffered_next      = buffered_reg;
        sent_next          = sent_reg;
        send_limit_next    = send_limit_reg;
        receive_limit_next = receive_limit_reg;
        last_blocked_next  = last_blocked_reg;
        status             = cfc_pkg::ST_OK;
        upd                = 1'b0;
        blk                = 1'b0;

        sum_c = {1'b0, consumed_reg} + {1'b0, amount};
        sum_b = {1'b0, buffered_reg} + {1'b0, amount};
        sum_s = {1'b0, sent_reg} + {1'b0, amount};
        left  = (consumed_reg > receive_limit_reg) ? '0 : receive_limit_reg - consumed_reg;
        sum_r = {1'b0, receive_limit_reg} + {1'b0, cfg.rx_window_max - left};

        if (cfg.enable) begin
            case (cfc_pkg::opcode_t'(opcode))
                cfc_pkg::OP_CONSUMED: begin
                    consumed_next = sum_c[W] ? cfc_pkg::OffsetMax : sum_c[W-1:0];
                end
                cfc_pkg::OP_BUFFERED: begin
                    buffered_next = sum_b[W] ? cfc_pkg::OffsetMax : sum_b[W-1:0];
                end
                cfc_pkg::OP_UNBUFFER: begin
                    if (buffered_reg < amount) begin
                        buffered_next = '0;
                        status        = cfc_pkg::ST_UNDERFLOW;
                    end else begin
                        buffered_next = buffered_reg - amount;
                    end
                end
                cfc_pkg::OP_SENT: begin
                    // also covers sent already past the limit
                    if (sum_s > {1'b0, send_limit_reg}) begin
                        sent_next = send_limit_reg;
                        status    = cfc_pkg::ST_OVERRUN;
                    end else begin
                        sent_next = sum_s[W-1:0];
                    end
                end
                cfc_pkg::OP_SEND_LIMIT: begin
                    if (amount <= send_limit_reg) begin
                        status = cfc_pkg::ST_NOT_RAISED;
                    end else begin
                        send_limit_next = amount;
                    end
                end
                cfc_pkg::OP_CHK_UPDATE: begin
                    if (left < (cfg.rx_window_max >> 1)) begin
                        receive_limit_next = sum_r[W] ? cfc_pkg::OffsetMax : sum_r[W-1:0];
                        upd = 1'b1;
                    end
                end
                cfc_pkg::OP_CHK_BLOCKED: begin
                    if (sent_reg >= send_limit_reg && last_blocked_reg < send_limit_reg) begin
                        last_blocked_next = send_limit_reg;
                        blk = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        window = (sent_next > send_limit_next) ? '0 : send_limit_next - sent_next;
        sum_cb = {1'b0, consumed_next} + {1'b0, buffered_next};

        result.status        = status;
        result.tx_credit     = window;
        result.is_blocked    = cfg.enable && (window == '0);
        result.violation     = cfg.enable && (sum_cb > {1'b0, receive_limit_next});
        result.update_sent   = upd;
        result.update_offset = receive_limit_next;
        result.blocked_sent  = blk;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            consumed_reg      <= '0;
            buffered_reg      <= '0;
            sent_reg          <= '0;
            send_limit_reg    <= cfc_pkg::InitialLimit;
            receive_limit_reg <= cfc_pkg::InitialLimit;
            last_blocked_reg  <= '0;
        end else begin
            if (advance) begin
                consumed_reg     <= consumed_next;
                buffered_reg     <= buffered_next;
                sent_reg         <= sent_next;
                last_blocked_reg <= last_blocked_next;
            end
            if (load.send_load) begin
                send_limit_reg <= load.value;
            end else if (advance) begin
                send_limit_reg <= send_limit_next;
            end
            if (load.receive_load) begin
                receive_limit_reg <= load.value;
            end else if (advance) begin
                receive_limit_reg <= receive_limit_next;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/credit_flow_controller.sv -----
// ----------------------------------------------------------------------------
// credit_flow_controller
// credit-based byte flow control for one stream
// ----------------------------------------------------------------------------
// usage:
//   s_ channel carries one event (opcode, amount) per transfer; m_ channel
//   returns exactly one result per event, in order
//   cfg_we/cfg_addr/cfg_wdata write one of the four control registers, chosen by cfg_addr;
//   writing a starting limit also loads it into the live limit, so write
//   only while no event is in flight
// path: an accepted event is evaluated in the input register against the
//   counters, and its result then moves into the result register, which
//   drives the m_ channel
// throughput: one event per cycle while m_ready is high; the counter update loop
//   (add, saturate, compare against the limits) sets this figure
// reset: counters and last blocked offset clear, both limits and the max
//   receive window go to 16384, flow control enabled, both channels empty
// stall: while m_ready is low the result holds, the input register keeps
//   its event, and s_ready drops once the input register is full
// ----------------------------------------------------------------------------
`default_nettype none

module credit_flow_controller (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    // event channel
    input  wire logic                                s_valid,
    output      logic                                s_ready,
    input  wire logic [cfc_pkg::OpcodeBits-1:0]      s_opcode,
    input  wire logic [cfc_pkg::OffsetBits-1:0]      s_amount,

    // result channel
    output      logic                                m_valid,
    input  wire logic                                m_ready,
    output      logic [cfc_pkg::StatusBits-1:0]      m_status,
    output      logic [cfc_pkg::OffsetBits-1:0]      m_tx_credit,
    output      logic                                m_is_blocked,
    output      logic                                m_violation,
    output      logic                                m_update_sent,
    output      logic [cfc_pkg::OffsetBits-1:0]      m_update_offset,
    output      logic                                m_blocked_sent,

    // register write port
    input  wire logic                                cfg_we,
    input  wire logic [cfc_pkg::CfgIndexBits-1:0]    cfg_addr,
    input  wire logic [cfc_pkg::OffsetBits-1:0]      cfg_wdata
);

    // input register
    logic                               in_valid_reg;
    logic [cfc_pkg::OpcodeBits-1:0]     in_opcode_reg;
    logic [cfc_pkg::OffsetBits-1:0]     in_amount_reg;

    // result register
    logic                               out_valid_reg;
    cfc_pkg::result_t                   result_reg;
    cfc_pkg::result_t                   result_next;

    // control registers
    logic                               enable_reg;
    logic [cfc_pkg::OffsetBits-1:0]     max_rx_window_reg;

    cfc_pkg::cfg_t                      cfg;
    cfc_pkg::limit_load_t               load;
    logic                               advance;
    logic                               s_xfer;

    // the evaluated event moves into the result register when it is free
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_xfer  = s_valid && s_ready;

    assign cfg.enable        = enable_reg;
    assign cfg.rx_window_max = max_rx_window_reg;

    // starting limits go straight into the live limits
    assign load.send_load    = cfg_we && (cfg_addr == cfc_pkg::CFG_INIT_SEND);
    assign load.receive_load = cfg_we && (cfg_addr == cfc_pkg::CFG_INIT_RECEIVE);
    assign load.value        = cfg_wdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg        <= 1'b1;
            max_rx_window_reg <= cfc_pkg::InitialLimit;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                cfc_pkg::CFG_ENABLE:        enable_reg        <= cfg_wdata[0];
                cfc_pkg::CFG_MAX_RX_WINDOW: max_rx_window_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // input register, refilled on every transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_xfer) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_opcode_reg <= s_opcode;
            in_amount_reg <= s_amount;
        end
    end

    cfc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .opcode  (in_opcode_reg),
        .amount  (in_amount_reg),
        .cfg     (cfg),
        .load    (load),
        .result  (result_next)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_status        = result_reg.status;
    assign m_tx_credit     = result_reg.tx_credit;
    assign m_is_blocked    = result_reg.is_blocked;
    assign m_violation     = result_reg.violation;
    assign m_update_sent   = result_reg.update_sent;
    assign m_update_offset = result_reg.update_offset;
    assign m_blocked_sent  = result_reg.blocked_sent;

endmodule

`default_nettype wire
